// File: rtl/pff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_pkg
// Shared item types and fixed field widths of the 2-D Pareto front filter.
// ----------------------------------------------------------------------------
package pff_pkg;

   // fixed widths of the item fields
   localparam int FIELD_W = 16;
   localparam int POS_W   = 6;

   // one input item: a point and its end-of-set mark
   typedef struct packed {
      logic signed [FIELD_W-1:0] point_f1;
      logic signed [FIELD_W-1:0] point_f2;
      logic                      last_point;
   } req_item_type;

   // one result item: a kept point with its load position
   typedef struct packed {
      logic signed [FIELD_W-1:0] out_f1;
      logic signed [FIELD_W-1:0] out_f2;
      logic [POS_W-1:0]          out_position;
      logic                      last_result;
      logic                      overflow;
   } rsp_item_type;

endpackage

// File: rtl/pff_point_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_point_mem
// Point storage: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pff_point_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write the loaded point, read two entries
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: rtl/pff_dom_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pff_dom_unit
// Shared compare unit: flags when the challenger point dominates the subject.
// ----------------------------------------------------------------------------
module pff_dom_unit #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic [2*VALUE_WIDTH-1:0] challenger,
   input  logic [2*VALUE_WIDTH-1:0] subject,
   input  logic                     same_point,
   output logic                     dominated
);

   logic signed [VALUE_WIDTH-1:0] c1, c2, s1, s2;
   logic ge_both;
   logic gt_one;

   // split the packed pairs into signed criteria
   assign c1 = signed'(challenger[2*VALUE_WIDTH-1:VALUE_WIDTH]);
   assign c2 = signed'(challenger[VALUE_WIDTH-1:0]);
   assign s1 = signed'(subject[2*VALUE_WIDTH-1:VALUE_WIDTH]);
   assign s2 = signed'(subject[VALUE_WIDTH-1:0]);

   // at least as large in both, strictly larger in one
   assign ge_both   = (c1 >= s1) && (c2 >= s2);
   assign gt_one    = (c1 > s1) || (c2 > s2);
   assign dominated = ge_both && gt_one && !same_point;

endmodule

// File: rtl/pareto_front_filter_2d_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_front_filter_2d_top
// Collects a set of 2-D points and emits the non-dominated ones in load order.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive req_item and raise start; the item is taken at an edge where
//    busy is low. A point arriving with MAX_POINTS already stored is dropped
//    and the set's overflow flag set.
//  - The point with last_point set starts the filter: each stored point is
//    checked against every stored point by one shared compare unit, one pair
//    per cycle.
//  - Output: every kept point appears on rsp_item for one cycle with
//    rsp_valid high, in load order; the last kept point carries last_result.
//    The receiver cannot stall the output.
//  - busy stays high after the edge that takes the last point of a set,
//    through the cycle in which its final result is out.
//  - Reset (synchronous, active high) empties the set and clears overflow.
// ----------------------------------------------------------------------------
module pareto_front_filter_2d_top #(
   parameter int MAX_POINTS  = 64,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pff_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output pff_pkg::rsp_item_type rsp_item
);

   import pff_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int PT_W  = 2 * VALUE_WIDTH;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CMP,
      ST_DRAIN,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic             p1_valid_ff, p1_valid_in;
   logic [IDX_W-1:0] p1_i_ff, p1_i_in;
   logic             p1_last_ff, p1_last_in;
   logic             p1_same_ff, p1_same_in;
   logic             acc_ff, acc_in;
   logic [IDX_W-1:0] last_kept_ff, last_kept_in;
   logic             e1_valid_ff, e1_valid_in;
   logic [IDX_W-1:0] e1_idx_ff, e1_idx_in;
   logic             kept_rd_ff;

   logic             kept_mem [MAX_POINTS];

   logic             accept;
   logic             full;
   logic [IDX_W-1:0] last_idx;
   logic             mem_we;
   logic [PT_W-1:0]  wr_point;
   logic [PT_W-1:0]  rd_a, rd_b;
   logic             dom_now;
   logic             kept_we;
   logic             kept_wdata;
   logic [VALUE_WIDTH-1:0] in_f1, in_f2;

   assign accept   = start && !busy;
   assign full     = (count_ff == CNT_W'(MAX_POINTS));
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   // take the field bits as VALUE_WIDTH-bit two's complement
   assign in_f1    = VALUE_WIDTH'($unsigned(req_item.point_f1));
   assign in_f2    = VALUE_WIDTH'($unsigned(req_item.point_f2));
   assign wr_point = {in_f1, in_f2};
   assign mem_we   = accept && !full;

   pff_point_mem #(
      .DEPTH (MAX_POINTS),
      .WIDTH (PT_W)
   ) u_point_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (count_ff[IDX_W-1:0]),
      .wr_data   (wr_point),
      .rd_addr_a (i_ff),
      .rd_addr_b (j_ff),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // pair read last cycle: does entry j dominate entry i
   pff_dom_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dom_unit (
      .challenger (rd_b),
      .subject    (rd_a),
      .same_point (p1_same_ff),
      .dominated  (dom_now)
   );

   // sequencer: load, compare sweep, emit
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      p1_valid_in  = 1'b0;
      p1_i_in      = i_ff;
      p1_last_in   = (j_ff == last_idx);
      p1_same_in   = (j_ff == i_ff);
      acc_in       = acc_ff;
      last_kept_in = last_kept_ff;
      e1_valid_in  = 1'b0;
      e1_idx_in    = i_ff;
      kept_we      = 1'b0;
      kept_wdata   = !(acc_ff || dom_now);

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_item.last_point) begin
                  state_in = ST_CMP;
                  i_in     = '0;
                  j_in     = '0;
               end
            end
         end
         ST_CMP: begin
            p1_valid_in = 1'b1;
            if (j_ff == last_idx) begin
               j_in = '0;
               if (i_ff == last_idx) begin
                  i_in     = '0;
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            e1_valid_in = 1'b1;
            if (i_ff == last_idx) begin
               i_in     = '0;
               state_in = ST_FLUSH;
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         ST_FLUSH: begin
            count_in = '0;
            ovf_in   = 1'b0;
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // fold the compare result into the subject's verdict
      if (p1_valid_ff) begin
         if (p1_last_ff) begin
            kept_we = 1'b1;
            acc_in  = 1'b0;
            if (kept_wdata) begin
               last_kept_in = p1_i_ff;
            end
         end else begin
            acc_in = acc_ff || dom_now;
         end
      end
   end

   // hold state and pipeline tags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         p1_valid_ff  <= 1'b0;
         acc_ff       <= 1'b0;
         e1_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         p1_valid_ff  <= p1_valid_in;
         acc_ff       <= acc_in;
         e1_valid_ff  <= e1_valid_in;
      end
      p1_i_ff      <= p1_i_in;
      p1_last_ff   <= p1_last_in;
      p1_same_ff   <= p1_same_in;
      last_kept_ff <= last_kept_in;
      e1_idx_ff    <= e1_idx_in;
   end

   // kept flag store: written per subject, read during emit
   always_ff @(posedge clock) begin
      if (kept_we) begin
         kept_mem[p1_i_ff] <= kept_wdata;
      end
      kept_rd_ff <= kept_mem[i_ff];
   end

   // drive the result item
   assign busy      = (state_ff != ST_LOAD);
   assign rsp_valid = e1_valid_ff && kept_rd_ff;
   assign rsp_item.out_f1       = signed'(FIELD_W'(rd_a[PT_W-1:VALUE_WIDTH]));
   assign rsp_item.out_f2       = signed'(FIELD_W'(rd_a[VALUE_WIDTH-1:0]));
   assign rsp_item.out_position = POS_W'(e1_idx_ff);
   assign rsp_item.last_result  = (e1_idx_ff == last_kept_ff);
   assign rsp_item.overflow     = ovf_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("stored point count beyond capacity");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result emitted while idle");

   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_result |=> !rsp_valid)
      else $error("result follows the last result of a set");

   a_start_filter: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.last_point |=> busy && count_ff != '0)
      else $error("filter started on an empty set");

   a_cmp_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> !p1_valid_ff)
      else $error("compare still in flight during emit");

endmodule

// File: test/pareto_front_filter_2d_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_front_filter_2d_top_test
// Self-checking bench for the 2-D Pareto front filter.
// Loads point sets through the start/busy port and predicts the kept points of
// each set in load order. Every strobed result is checked against the oldest
// prediction. The run starts with hand-picked sets: extremes, ties, equal
// duplicates, and -100 as an ordinary value. Random sets follow: mostly small,
// plus one set past capacity and one set exactly full. Sender gaps are random.
// ----------------------------------------------------------------------------
module pareto_front_filter_2d_top_test;
   import pff_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int PERIOD       = 10;
   localparam int RANDOM_ITEMS = 250;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 50;
   localparam int TIMEOUT_NS   = 5000000;

   typedef logic signed [FIELD_W-1:0] value_type;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_item_type req_item = '0;
   logic         busy;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   // Predict the kept points of each set and check the strobed results
   class pareto_scoreboard;
      value_type    f1_store [CAPACITY];
      value_type    f2_store [CAPACITY];
      int           loaded;
      bit           dropped_any;
      rsp_item_type front_queue [$];
      int           mismatch_count;

      function new();
         loaded         = 0;
         dropped_any    = 1'b0;
         mismatch_count = 0;
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: %s", $time, msg);
         mismatch_count++;
      endtask

      function int pending();
         return front_queue.size();
      endfunction

      // true if stored point a dominates stored point b
      function bit beats(int a, int b);
         return f1_store[a] >= f1_store[b] && f2_store[a] >= f2_store[b] &&
                (f1_store[a] > f1_store[b] || f2_store[a] > f2_store[b]);
      endfunction

      // Filter the stored set and queue its kept points in load order
      function void predict_front();
         bit           kept [CAPACITY];
         int           last_kept;
         rsp_item_type res;
         last_kept = 0;
         for (int i = 0; i < loaded; i++) begin
            kept[i] = 1'b1;
            for (int j = 0; j < loaded; j++) begin
               if (j != i && beats(j, i))
                  kept[i] = 1'b0;
            end
            if (kept[i])
               last_kept = i;
         end
         for (int i = 0; i < loaded; i++) begin
            if (kept[i]) begin
               res.out_f1       = f1_store[i];
               res.out_f2       = f2_store[i];
               res.out_position = POS_W'(i);
               res.last_result  = (i == last_kept);
               res.overflow     = dropped_any;
               front_queue.push_back(res);
            end
         end
      endfunction

      // Store an accepted item; a marked last item closes the set
      function void note_point(req_item_type item);
         if (loaded < CAPACITY) begin
            f1_store[loaded] = item.point_f1;
            f2_store[loaded] = item.point_f2;
            loaded++;
         end else begin
            dropped_any = 1'b1;
         end
         if (item.last_point) begin
            predict_front();
            loaded      = 0;
            dropped_any = 1'b0;
         end
      endfunction

      task check_result(rsp_item_type got);
         rsp_item_type want;
         if (front_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected result f1=%0d f2=%0d pos=%0d",
                                      got.out_f1, got.out_f2, got.out_position));
            return;
         end
         want = front_queue.pop_front();
         if (got.out_f1 !== want.out_f1)
            report_mismatch($sformatf("out_f1 %0d, expected %0d (pos %0d)",
                                      got.out_f1, want.out_f1, want.out_position));
         if (got.out_f2 !== want.out_f2)
            report_mismatch($sformatf("out_f2 %0d, expected %0d (pos %0d)",
                                      got.out_f2, want.out_f2, want.out_position));
         if (got.out_position !== want.out_position)
            report_mismatch($sformatf("out_position %0d, expected %0d",
                                      got.out_position, want.out_position));
         if (got.last_result !== want.last_result)
            report_mismatch($sformatf("last_result %b, expected %b (pos %0d)",
                                      got.last_result, want.last_result,
                                      want.out_position));
         if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b (pos %0d)",
                                      got.overflow, want.overflow, want.out_position));
      endtask

      task flag_leftover();
         if (front_queue.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      front_queue.size()));
      endtask
   endclass

   pareto_scoreboard front_board = new();
   int               items_sent  = 0;

   pareto_front_filter_2d_top #(
      .MAX_POINTS  (CAPACITY),
      .VALUE_WIDTH (FIELD_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Check each strobed result at the edge that ends its cycle
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1)
         front_board.check_result(rsp_item);
   end

   function automatic req_item_type make_point(value_type f1, value_type f2, bit last);
      req_item_type item;
      item.point_f1   = f1;
      item.point_f2   = f2;
      item.last_point = last;
      return item;
   endfunction

   // Narrow band for ties, full range, or a corner value
   function automatic value_type pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return value_type'($urandom_range(0, 7)) - value_type'(4);
      if (r < 8)
         return value_type'($urandom_range(0, 65535));
      case ($urandom_range(0, 4))
         0:       return value_type'(16'h8000);
         1:       return value_type'(16'h7fff);
         2:       return value_type'(-100);
         3:       return value_type'(0);
         default: return value_type'(-1);
      endcase
   endfunction

   // Mostly back to back or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10)
         return 0;
      if (r < 17)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Hold the item until an edge with busy low takes it
   task automatic send_point(input req_item_type item);
      req_item <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      front_board.note_point(item);
      items_sent++;
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Hold off the next item until the whole front has come out
   task automatic wait_front_drained();
      start <= 1'b0;
      do @(posedge clock); while (front_board.pending() != 0);
   endtask

   initial begin
      int        set_index;
      int        big_sets;
      int        set_size;
      int        drain;
      bit        diagonal;
      bit        steady;
      value_type f1;
      value_type f2;
      set_index = 0;
      big_sets  = 0;
      drain     = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single point at the negative extreme
      send_point(make_point(16'sh8000, 16'sh8000, 1'b1));
      // equal duplicates of -100, both kept
      send_point(make_point(-16'sd100, -16'sd100, 1'b0));
      idle_gap(2);
      send_point(make_point(-16'sd100, -16'sd100, 1'b1));
      // incomparable extremes, ties, and a tie broken in one criterion
      send_point(make_point(16'sh7fff, 16'sh8000, 1'b0));
      send_point(make_point(16'sh8000, 16'sh7fff, 1'b0));
      send_point(make_point(16'sd0, 16'sd0, 1'b0));
      idle_gap(1);
      send_point(make_point(-16'sd1, -16'sd1, 1'b0));
      send_point(make_point(16'sd0, 16'sd0, 1'b0));
      send_point(make_point(-16'sd100, 16'sh7fff, 1'b1));
      wait_front_drained();
      // last kept point is not the last loaded
      send_point(make_point(16'sd5, 16'sd3, 1'b0));
      send_point(make_point(16'sd5, 16'sd4, 1'b0));
      send_point(make_point(16'sd4, 16'sd4, 1'b1));
      // alternating bit patterns under a dominating maximum
      send_point(make_point(16'sh7fff, 16'sh7fff, 1'b0));
      send_point(make_point(16'shaaaa, 16'sh5555, 1'b0));
      send_point(make_point(16'sh5555, 16'shaaaa, 1'b1));
      wait_front_drained();

      // Random sets: mostly small, every sixteenth one at or past capacity
      while (items_sent < RANDOM_ITEMS) begin
         if (set_index % 16 == 5) begin
            set_size = (big_sets % 2 == 0) ? $urandom_range(CAPACITY + 1, CAPACITY + 6)
                                           : CAPACITY;
            big_sets++;
         end else begin
            set_size = $urandom_range(1, 8);
         end
         diagonal = ($urandom_range(0, 3) == 0);
         steady   = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < set_size; k++) begin
            f1 = pick_value();
            // anti-diagonal points are mutually incomparable unless nudged
            f2 = diagonal ? ~f1 + value_type'($urandom_range(0, 1)) : pick_value();
            send_point(make_point(f1, f2, k == set_size - 1));
            if (!steady)
               idle_gap(pick_gap());
         end
         if ($urandom_range(0, 5) == 0)
            wait_front_drained();
         set_index++;
      end

      // Drain the remaining results, then allow a short tail
      start <= 1'b0;
      while (front_board.pending() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      front_board.flag_leftover();
      if (front_board.mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stop a hung run
   initial begin
      #(TIMEOUT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
